/* hw/rtl/four_stacks_in_shared_memory_unit_defines.svh */
// Assertion helpers used by the stack unit RTL.
`ifndef FOUR_STACKS_IN_SHARED_MEMORY_UNIT_DEFINES_SVH
`define FOUR_STACKS_IN_SHARED_MEMORY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FSS_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSS_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fss_pkg.sv */
`timescale 1ns / 1ps

package fss_pkg;

  // Default size of the shared store, in words.
  localparam int STORE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int NUM_STACKS  = 4;

  // Command codes; the fourth code is a no-op.
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

endpackage

/* hw/rtl/fss_channels_if.sv */
`timescale 1ns / 1ps

// Command channel: one stack operation per beat.
interface fss_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic [1:0]                        stack_id;
  logic signed [fss_pkg::DATA_W-1:0] push_value;

  modport source (output valid, command, stack_id, push_value, input ready);
  modport sink   (input valid, command, stack_id, push_value, output ready);
endinterface

// Result channel: one result per command.
interface fss_res_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [fss_pkg::DATA_W-1:0] top_value;

  modport source (output valid, status, top_value, input ready);
  modport sink   (input valid, status, top_value, output ready);
endinterface

/* hw/rtl/fss_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module fss_ram #(
  parameter int WIDTH = fss_pkg::DATA_W,
  parameter int DEPTH = fss_pkg::STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/four_stacks_in_shared_memory_unit.sv */
`timescale 1ns / 1ps
//  channel  dir  fields                          beat
//  cmd      in   command, stack_id, push_value   one stack operation
//  res      out  status, top_value               one result per command
//
//  One command per cycle unless the result slot is stalled; its result appears the cycle after acceptance.
//  Stack counts and the result slot live in flip-flops; the store is one RAM
//  with a single write and a single registered read port, used at most once per command.
//  Synchronous reset empties all four stacks; store contents are not cleared.
//  cmd.ready is low in reset, else drops only while a result is held and res.ready is low.

`include "four_stacks_in_shared_memory_unit_defines.svh"

module four_stacks_in_shared_memory_unit #(
  parameter int STORE_DEPTH = fss_pkg::STORE_DEPTH
) (
  input logic     clk,
  input logic     rst,
  fss_cmd_if.sink cmd,
  fss_res_if.source res
);

  localparam int HALF = STORE_DEPTH / 2;
  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int CW   = $clog2(HALF + 1);
  localparam int NS   = fss_pkg::NUM_STACKS;

  // Per-stack element counts.
  logic [CW-1:0] cnt      [NS];
  logic [CW-1:0] cnt_next [NS];

  // Result slot.
  logic                   out_valid;
  fss_pkg::status_t       out_status;
  logic                   out_use_rd;
  logic [fss_pkg::DATA_W-1:0] rd_data;

  logic cmd_fire;
  logic is_push;
  logic is_read;
  logic is_pop;

  // Per-stack conditions and addresses, each at a fixed place.
  logic [NS-1:0] full;
  logic [NS-1:0] empty;
  logic [AW-1:0] wr_addr_l [NS];
  logic [AW-1:0] rd_addr_l [NS];

  logic          sel_full;
  logic          sel_empty;
  logic          do_write;
  logic          do_read;

  assign cmd.ready = !rst && (!out_valid || res.ready);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign is_push   = cmd.command == fss_pkg::CMD_PUSH;
  assign is_pop    = cmd.command == fss_pkg::CMD_POP;
  assign is_read   = is_pop || (cmd.command == fss_pkg::CMD_PEEK);

  // Lane logic: fullness of the half, emptiness, next push and top address.
  for (genvar g = 0; g < NS; g++) begin : g_lane
    localparam logic [AW-1:0] BASE = AW'((g / 2) * HALF);
    localparam logic [AW-1:0] TOPW = AW'((g / 2) * HALF + HALF - 1);
    logic [AW-1:0] pos;

    assign pos      = AW'(cnt[g]);
    assign full[g]  = ({1'b0, cnt[g]} + {1'b0, cnt[g ^ 1]}) >= (CW + 1)'(HALF);
    assign empty[g] = cnt[g] == '0;

    if ((g % 2) == 0) begin : g_up
      assign wr_addr_l[g] = BASE + pos;
      assign rd_addr_l[g] = BASE + pos - AW'(1);
    end else begin : g_down
      assign wr_addr_l[g] = TOPW - pos;
      assign rd_addr_l[g] = TOPW - pos + AW'(1);
    end
  end

  assign sel_full  = full[cmd.stack_id];
  assign sel_empty = empty[cmd.stack_id];
  assign do_write  = cmd_fire && is_push && !sel_full;
  assign do_read   = cmd_fire && is_read && !sel_empty;

  // Count update.
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      cnt_next[i] = cnt[i];
      if (cmd.stack_id == 2'(i)) begin
        if (do_write) begin
          cnt_next[i] = cnt[i] + CW'(1);
        end else if (do_read && is_pop) begin
          cnt_next[i] = cnt[i] - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      cnt <= cnt_next;
    end
  end

  // Shared element store.
  fss_ram #(
    .WIDTH (fss_pkg::DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (do_write),
    .waddr (wr_addr_l[cmd.stack_id]),
    .wdata (cmd.push_value),
    .re    (do_read),
    .raddr (rd_addr_l[cmd.stack_id]),
    .rdata (rd_data)
  );

  // Result register; the RAM read register holds while the slot is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_fire) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      out_use_rd <= do_read;
      if (is_push && sel_full) begin
        out_status <= fss_pkg::ST_OVERFLOW;
      end else if (is_read && sel_empty) begin
        out_status <= fss_pkg::ST_EMPTY;
      end else begin
        out_status <= fss_pkg::ST_DONE;
      end
    end
  end

  assign res.valid     = out_valid;
  assign res.status    = out_status;
  assign res.top_value = out_use_rd ? rd_data : '0;

  // Checks.
  `FSS_ASSERT_NOW(a_low_half_fits, clk, rst, 1'b1,
    ({1'b0, cnt[0]} + {1'b0, cnt[1]}) <= (CW + 1)'(HALF), "lower half overfilled")
  `FSS_ASSERT_NOW(a_high_half_fits, clk, rst, 1'b1,
    ({1'b0, cnt[2]} + {1'b0, cnt[3]}) <= (CW + 1)'(HALF), "upper half overfilled")
  `FSS_ASSERT_NEXT(a_push_counts, clk, rst, do_write,
    cnt[$past(cmd.stack_id)] == $past(cnt[cmd.stack_id]) + CW'(1), "push lost count")
  `FSS_ASSERT_NOW(a_err_zero_top, clk, rst, out_valid && out_status != fss_pkg::ST_DONE,
    !out_use_rd, "error result carries data")
  `FSS_ASSERT_NOW(a_ready_only_stall, clk, rst, !cmd.ready,
    out_valid && !res.ready, "ready low without stall")

endmodule
